// ===== rtl/ddec_pkg.sv =====
// ----------------------------------------------------------------------------
// ddec_pkg
// types and fixed field widths shared by the dual encoder counter files
// ----------------------------------------------------------------------------
package ddec_pkg;

    localparam int unsigned COUNT_FIELD_W = 10;
    localparam int unsigned MODE_W        = 2;
    localparam int unsigned BAR_W         = 3;

    // mode code that freezes the count
    localparam logic [MODE_W-1:0] MODE_HOLD = 2'd3;
    localparam logic [MODE_W-1:0] MODE_UNIT = 2'd0;

    typedef struct packed {
        logic enc1_a;
        logic enc1_b;
        logic enc2_a;
        logic enc2_b;
        logic button0_pin;
        logic button1_pin;
    } t_in_item;

    typedef struct packed {
        logic [COUNT_FIELD_W-1:0] count_value;
        logic [MODE_W-1:0]        mode_bits;
        logic [BAR_W-1:0]         bar_pattern;
    } t_out_item;

endpackage

// ===== rtl/ddec_if.sv =====
// ----------------------------------------------------------------------------
// ddec_if
// valid/ready channel carrying one payload item per transaction
// ----------------------------------------------------------------------------
interface ddec_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/debounced_dual_encoder_counter_core.sv =====
// ----------------------------------------------------------------------------
// debounced_dual_encoder_counter_core
// two quadrature encoders driving one wrapped count, with two debounced
// buttons selecting the step exponent
// ----------------------------------------------------------------------------
//
//  channel | dir | payload                                      | handshake
//  --------+-----+----------------------------------------------+-----------
//  i_in    | in  | enc1_a enc1_b enc2_a enc2_b button0/1_pin    | valid/ready
//  o_out   | out | count_value[9:0] mode_bits[1:0] bar_pattern  | valid/ready
//
//  one transaction per cycle sustained while o_out.ready holds; each item
//  passes the input register, then the result register
//  the state update (debounce, mode, count) is a single combinational step
//  between the input register and the result register
//  synchronous active-low reset: history zeros, mode 0, count 1, prev bits 0
//  a stalled output holds the result register; the input register still
//  accepts one more transaction before i_in.ready drops
//
module debounced_dual_encoder_counter_core
    import ddec_pkg::*;
#(
    parameter int unsigned DEBOUNCE_SAMPLES = 12,
    parameter int unsigned COUNT_MODULUS    = 1024
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    ddec_if.sink   i_in,
    ddec_if.source o_out
);

    // history keeps one released sample plus the pressed run
    localparam int unsigned HIST_W  = DEBOUNCE_SAMPLES + 1;
    localparam int unsigned COUNT_W = $clog2(COUNT_MODULUS);
    localparam logic [HIST_W-1:0]  HIST_FIRE  = HIST_W'(1) << DEBOUNCE_SAMPLES;
    localparam logic [COUNT_W:0]   MOD_EXT    = (COUNT_W + 1)'(COUNT_MODULUS);
    localparam logic [COUNT_W-1:0] COUNT_INIT = COUNT_W'(1);

    // one encoder step on the count; both adds stay below twice the modulus
    function automatic logic [COUNT_W-1:0] enc_step(
        input logic [COUNT_W-1:0] count,
        input logic [MODE_W-1:0]  mode,
        input logic               a,
        input logic               b,
        input logic               pa,
        input logic               pb
    );
        logic [COUNT_W:0] step;
        logic [COUNT_W:0] cnt;
        logic [COUNT_W:0] sum;
        logic [COUNT_W:0] res;
        step = (COUNT_W + 1)'(1) << mode;
        cnt  = {1'b0, count};
        sum  = cnt + step;
        res  = cnt;
        if (a && pa) begin
            if (!pb && b) begin
                res = (sum >= MOD_EXT) ? (sum - MOD_EXT) : sum;
            end else if (pb && !b) begin
                res = (cnt >= step) ? (cnt - step) : (cnt + MOD_EXT - step);
            end
        end
        return res[COUNT_W-1:0];
    endfunction

    // pipeline control
    logic      r_in_valid;
    t_in_item  r_in_data;
    logic      r_out_valid;
    t_out_item r_out_data;
    logic      w_out_free;
    logic      w_adv;
    logic      w_accept;

    // block state
    logic [HIST_W-1:0]  r_hist0, r_hist1;
    logic [HIST_W-1:0]  n_hist0, n_hist1;
    logic [MODE_W-1:0]  r_mode, n_mode;
    logic [COUNT_W-1:0] r_count, n_count, w_count_mid;
    logic [3:0]         r_prev, n_prev;
    logic               w_fire0, w_fire1;
    logic [31:0]        w_count_ext;
    logic [BAR_W-1:0]   w_bar;

    // result register drains when taken; input register moves when it can
    assign w_out_free  = !r_out_valid || o_out.ready;
    assign w_adv       = r_in_valid && w_out_free;
    assign i_in.ready  = !r_in_valid || w_out_free;
    assign w_accept    = i_in.valid && i_in.ready;

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out_data;

    // debounce: fire once on a released sample followed by the pressed run
    assign n_hist0 = {r_hist0[HIST_W-2:0], r_in_data.button0_pin};
    assign n_hist1 = {r_hist1[HIST_W-2:0], r_in_data.button1_pin};
    assign w_fire0 = (n_hist0 == HIST_FIRE);
    assign w_fire1 = (n_hist1 == HIST_FIRE);
    assign n_mode  = r_mode ^ {w_fire1, w_fire0};

    // encoder one first, then encoder two on its result
    always_comb begin
        w_count_mid = r_count;
        n_count     = r_count;
        if (n_mode != MODE_HOLD) begin
            w_count_mid = enc_step(r_count, n_mode, r_in_data.enc1_a, r_in_data.enc1_b,
                                   r_prev[0], r_prev[1]);
            n_count     = enc_step(w_count_mid, n_mode, r_in_data.enc2_a,
                                   r_in_data.enc2_b, r_prev[2], r_prev[3]);
        end
    end

    assign n_prev = {r_in_data.enc2_b, r_in_data.enc2_a,
                     r_in_data.enc1_b, r_in_data.enc1_a};

    assign w_count_ext = 32'(n_count);
    assign w_bar       = (n_mode == MODE_UNIT) ? BAR_W'(1) : BAR_W'({n_mode, 1'b0});

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
        if (w_accept) begin
            r_in_data <= i_in.data;
        end
    end

    // state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_hist0     <= '0;
            r_hist1     <= '0;
            r_mode      <= '0;
            r_count     <= COUNT_INIT;
            r_prev      <= '0;
        end else begin
            if (w_out_free) begin
                r_out_valid <= r_in_valid;
            end
            if (w_adv) begin
                r_hist0 <= n_hist0;
                r_hist1 <= n_hist1;
                r_mode  <= n_mode;
                r_count <= n_count;
                r_prev  <= n_prev;
            end
        end
        if (w_adv) begin
            r_out_data.count_value <= w_count_ext[COUNT_FIELD_W-1:0];
            r_out_data.mode_bits   <= n_mode;
            r_out_data.bar_pattern <= w_bar;
        end
    end

    // count never leaves its range
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_count} < MOD_EXT))
        else $error("count out of range");

    // hold mode freezes the count across an update
    a_hold_freezes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && n_mode == MODE_HOLD) |=> $stable(r_count))
        else $error("count moved in hold mode");

    // a waiting input item is never dropped
    a_in_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_adv) |=> (r_in_valid && $stable(r_in_data)))
        else $error("input register lost an item");

    // button zero never fires on two updates in a row
    a_fire_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && w_fire0) |=> !(w_adv && w_fire0))
        else $error("button zero fired twice in a row");

    // reported mode matches the internal mode after each update
    a_mode_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv |=> (r_out_data.mode_bits == r_mode))
        else $error("result mode does not match state");

endmodule

// ===== tb/debounced_dual_encoder_counter_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// debounced_dual_encoder_counter_core_tb
// drives pin samples through the dual encoder counter and checks every result
// against an in-bench model of debounce, mode toggling and wrapped counting
// ----------------------------------------------------------------------------
module debounced_dual_encoder_counter_core_tb;
    import ddec_pkg::*;

    localparam int unsigned DEB_N        = 12;
    localparam int unsigned HIST_W       = DEB_N + 1;
    localparam int unsigned LIMIT_CYCLES = 200000;

    // released sample followed by DEB_N pressed samples
    localparam logic [HIST_W-1:0] HIST_FIRE = 1 << DEB_N;

    // a1 b1 a2 b2 p0 p1 per sample, first sample in the top six bits
    localparam logic [119:0] DIRECTED_SAMPLES = {
        6'b010000, 6'b110000, 6'b100000, 6'b000011, 6'b010000,
        6'b110000, 6'b100000, 6'b000000, 6'b001000, 6'b001100,
        6'b000100, 6'b000000, 6'b101000, 6'b111100, 6'b010100,
        6'b000000, 6'b101000, 6'b111100, 6'b101011, 6'b111111
    };

    logic i_clk;
    logic i_rst_n;

    ddec_if #(.T(t_in_item))  in_if ();
    ddec_if #(.T(t_out_item)) out_if ();

    debounced_dual_encoder_counter_core u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // model state, at reset values; the modulus is 2^COUNT_FIELD_W so the
    // count wraps by plain overflow of its field
    logic [HIST_W-1:0]        btn_hist [2] = '{default: '0};
    logic [MODE_W-1:0]        mode_q       = MODE_UNIT;
    logic [COUNT_FIELD_W-1:0] count_q      = 1;
    logic [3:0]               prev_bits    = '0;

    t_out_item   pending_counts [$];
    int unsigned mismatches  = 0;
    int unsigned cycle_count = 0;

    // idling control: calm means no gaps on that side
    bit tx_calm = 1'b0;
    bit rx_calm = 1'b0;

    // stimulus generator state
    logic [1:0]  enc_pos    [2] = '{default: '0};
    bit          enc_fwd    [2] = '{default: 1'b1};
    int unsigned press_left [2] = '{default: 0};

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // one tick of the counter: buttons first, then encoder one, then two
    function automatic t_out_item step_counter_model(input t_in_item s);
        logic [HIST_W-1:0]        h;
        logic [1:0]               pins;
        logic [3:0]               now_bits;
        logic [COUNT_FIELD_W-1:0] incr;
        logic                     a, b, pa, pb;
        t_out_item                r;
        pins     = {s.button1_pin, s.button0_pin};
        now_bits = {s.enc2_b, s.enc2_a, s.enc1_b, s.enc1_a};
        for (int i = 0; i < 2; i++) begin
            h = {btn_hist[i][HIST_W-2:0], pins[i]};
            btn_hist[i] = h;
            if (h == HIST_FIRE) begin
                mode_q[i] = ~mode_q[i];
            end
        end
        if (mode_q != MODE_HOLD) begin
            incr = COUNT_FIELD_W'(1) << mode_q;
            for (int e = 0; e < 2; e++) begin
                a  = now_bits[2*e];
                b  = now_bits[2*e+1];
                pa = prev_bits[2*e];
                pb = prev_bits[2*e+1];
                // a held high: b rising counts up, b falling counts down
                if (a && pa && !pb && b) begin
                    count_q = count_q + incr;
                end else if (a && pa && pb && !b) begin
                    count_q = count_q - incr;
                end
            end
        end
        prev_bits     = now_bits;
        r.count_value = count_q;
        r.mode_bits   = mode_q;
        r.bar_pattern = (mode_q == MODE_UNIT) ? BAR_W'(1) : {mode_q, 1'b0};
        return r;
    endfunction

    function automatic void check_field(input string what, input logic [15:0] got,
                                        input logic [15:0] want);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, what, want, got);
            mismatches++;
        end
    endfunction

    // every result transaction against the oldest expectation
    always @(posedge i_clk) begin : check_results
        t_out_item want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (pending_counts.size() == 0) begin
                $display("%0t: unexpected result, expected none actual count %0d mode %0d",
                         $time, out_if.data.count_value, out_if.data.mode_bits);
                mismatches++;
            end else begin
                want = pending_counts.pop_front();
                check_field("count_value", 16'(out_if.data.count_value),
                            16'(want.count_value));
                check_field("mode_bits", 16'(out_if.data.mode_bits), 16'(want.mode_bits));
                check_field("bar_pattern", 16'(out_if.data.bar_pattern),
                            16'(want.bar_pattern));
            end
        end
    end

    // receiver: a stall of random length, none when rx_calm, drawn before each result
    initial begin : result_sink
        int unsigned stall;
        out_if.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            stall = rx_calm ? 0 : $urandom_range(0, 8);
            if (stall > 0) begin
                out_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_if.ready <= 1'b1;
            @(posedge i_clk);
            while (!out_if.valid) @(posedge i_clk);
        end
    end

    // one sample transaction, prediction queued at acceptance
    task automatic push_sample(input t_in_item s);
        int unsigned gap;
        in_if.valid <= 1'b1;
        in_if.data  <= s;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        pending_counts.push_back(step_counter_model(s));
        gap = tx_calm ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // sender holds off until the block has drained
    task automatic wait_for_results();
        in_if.valid <= 1'b0;
        while (pending_counts.size() != 0) @(posedge i_clk);
    endtask

    // quadrature walks on both encoders with press sequences on the buttons;
    // noise_pct of the samples are replaced by random pin levels
    task automatic run_encoder_session(input int unsigned n, input int unsigned press_pct,
                                       input int unsigned noise_pct);
        t_in_item    s;
        logic [1:0]  pins;
        int unsigned r;
        for (int unsigned k = 0; k < n; k++) begin
            if (k % 64 == 0) begin
                tx_calm = ($urandom_range(0, 2) == 0);
                rx_calm = ($urandom_range(0, 2) == 0);
            end
            for (int e = 0; e < 2; e++) begin
                r = $urandom_range(0, 99);
                if (r < 8) begin
                    enc_fwd[e] = !enc_fwd[e];
                end
                if (r < 75) begin
                    enc_pos[e] = enc_fwd[e] ? enc_pos[e] + 2'd1 : enc_pos[e] - 2'd1;
                end
            end
            for (int i = 0; i < 2; i++) begin
                if (press_left[i] == 0) begin
                    // released sample; a press may start on the next one
                    pins[i] = 1'b1;
                    if ($urandom_range(0, 99) < press_pct) begin
                        press_left[i] = $urandom_range(6, 18);
                    end
                end else begin
                    press_left[i]--;
                    // occasional contact bounce during a press
                    pins[i] = ($urandom_range(0, 99) < 3);
                end
            end
            // gray position to pins: 0 -> 00, 1 -> 10, 2 -> 11, 3 -> 01 (a b)
            s.enc1_a      = enc_pos[0][0] ^ enc_pos[0][1];
            s.enc1_b      = enc_pos[0][1];
            s.enc2_a      = enc_pos[1][0] ^ enc_pos[1][1];
            s.enc2_b      = enc_pos[1][1];
            s.button0_pin = pins[0];
            s.button1_pin = pins[1];
            if ($urandom_range(0, 99) < noise_pct) begin
                s = t_in_item'(6'($urandom_range(0, 63)));
            end
            push_sample(s);
        end
    endtask

    // wrap below zero on encoder one, wrap above 1023 on encoder two, both
    // encoders in one tick, buttons held from reset, both buttons firing
    // together into the hold mode, held buttons not firing again
    task automatic test_directed_sequence();
        tx_calm = 1'b0;
        rx_calm = 1'b0;
        for (int i = 0; i < 20; i++) begin
            push_sample(t_in_item'(DIRECTED_SAMPLES[119 - 6*i -: 6]));
        end
    endtask

    // mostly clean counting, rare mode changes
    task automatic test_counting_walks();
        run_encoder_session(450, 1, 3);
    endtask

    // frequent presses cycle the mode through all four values
    task automatic test_mode_changes();
        run_encoder_session(450, 8, 3);
    endtask

    // every pin random on every sample
    task automatic test_raw_noise();
        run_encoder_session(120, 0, 100);
    endtask

    // heavy pressing mixed with broken sequences
    task automatic test_broken_sequences();
        run_encoder_session(110, 15, 20);
    endtask

    initial begin
        i_rst_n     <= 1'b0;
        in_if.valid <= 1'b0;
        in_if.data  <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_sequence();
        wait_for_results();
        test_counting_walks();
        test_mode_changes();
        wait_for_results();
        test_raw_noise();
        test_broken_sequences();
        wait_for_results();

        // quiet cycles after the drain catch any stray result
        repeat (8) @(posedge i_clk);
        if (mismatches == 0 && pending_counts.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
